// ===== rtl/dasp_pkg.sv =====
// dasp_pkg: shared types, widths and register codes of the dual-axis step pulse scheduler
// no dependencies; imported by every module under rtl
package dasp_pkg;

	// counter and compare width
	localparam int CNT_W = 32;
	// configuration port
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W = 3;
	// compare channels
	localparam int NUM_CH = 4;
	localparam int CH_W = 2;

	// step pulse high time in counts
	localparam logic [CNT_W-1:0] PULSE_COUNTS = CNT_W'(10);
	// reset values
	localparam logic [CNT_W-1:0] CH1_RESET_COMPARE = CNT_W'(500);
	localparam logic [CNT_W-1:0] DEFAULT_PERIOD = CNT_W'(10000);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIDEREAL_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIDEREAL_ENABLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_A_PERIOD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_A_ENABLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_B_PERIOD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_B_ENABLE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CONTROL_PERIOD = 3'd6;

	// channel numbers
	localparam logic [CH_W-1:0] CH_SIDEREAL = 2'd0;
	localparam logic [CH_W-1:0] CH_AXIS_A = 2'd1;
	localparam logic [CH_W-1:0] CH_AXIS_B = 2'd2;
	localparam logic [CH_W-1:0] CH_CONTROL = 2'd3;

	// configuration as seen by the compare core
	typedef struct packed {
		logic [CNT_W-1:0] sid_period;
		logic             sid_en;
		logic [CNT_W-1:0] a_period;
		logic [CNT_W-1:0] a_low_span;
		logic             a_en;
		logic [CNT_W-1:0] b_period;
		logic [CNT_W-1:0] b_low_span;
		logic             b_en;
		logic [CNT_W-1:0] ctl_period;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic a_level;
		logic b_level;
		logic a_started;
		logic b_started;
		logic sid_tick;
		logic ctl_tick;
	} res_t;

endpackage

// ===== rtl/dasp_cfg_regs.sv =====
// dasp_cfg_regs: configuration registers written through the plain write port
// depends on dasp_pkg; also keeps the low time of each axis (period minus pulse) ready
module dasp_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [dasp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dasp_pkg::CFG_DATA_W-1:0] cfg_data,
	output dasp_pkg::cfg_t                  cfg
);
	import dasp_pkg::*;

	cfg_t cfg_q;
	logic [CNT_W-1:0] data_cnt;

	// register data brought to counter width
	assign data_cnt = CNT_W'(cfg_data);

	// register file; low spans wrap modulo the counter width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sid_period <= DEFAULT_PERIOD;
			cfg_q.sid_en     <= 1'b0;
			cfg_q.a_period   <= DEFAULT_PERIOD;
			cfg_q.a_low_span <= DEFAULT_PERIOD - PULSE_COUNTS;
			cfg_q.a_en       <= 1'b0;
			cfg_q.b_period   <= DEFAULT_PERIOD;
			cfg_q.b_low_span <= DEFAULT_PERIOD - PULSE_COUNTS;
			cfg_q.b_en       <= 1'b0;
			cfg_q.ctl_period <= DEFAULT_PERIOD;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SIDEREAL_PERIOD: cfg_q.sid_period <= data_cnt;
				REG_SIDEREAL_ENABLE: cfg_q.sid_en <= cfg_data[0];
				REG_AXIS_A_PERIOD: begin
					cfg_q.a_period   <= data_cnt;
					cfg_q.a_low_span <= data_cnt - PULSE_COUNTS;
				end
				REG_AXIS_A_ENABLE: cfg_q.a_en <= cfg_data[0];
				REG_AXIS_B_PERIOD: begin
					cfg_q.b_period   <= data_cnt;
					cfg_q.b_low_span <= data_cnt - PULSE_COUNTS;
				end
				REG_AXIS_B_ENABLE: cfg_q.b_en <= cfg_data[0];
				REG_CONTROL_PERIOD: cfg_q.ctl_period <= data_cnt;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/dasp_compare_core.sv =====
// dasp_compare_core: counter stepped per accepted count, four compare channels, pending flags and pin phases
// depends on dasp_pkg; state advances on each accepted count from the input stage
module dasp_compare_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           advance,
	input  dasp_pkg::cfg_t cfg,
	output dasp_pkg::res_t res
);
	import dasp_pkg::*;

	logic [CNT_W-1:0]  counter_q;
	logic [CNT_W-1:0]  compare_q [NUM_CH];
	logic [NUM_CH-1:0] pending_q;
	logic              phase_a_q;
	logic              phase_b_q;

	logic              update;
	logic [CNT_W-1:0]  cnt_next;
	logic [NUM_CH-1:0] match;
	logic [NUM_CH-1:0] pend;
	logic [NUM_CH-1:0] pend_next;
	logic              any;
	logic [CH_W-1:0]   chan;
	logic [CNT_W-1:0]  delta;
	logic [CNT_W-1:0]  cmp_next;
	logic              a_start;
	logic              b_start;
	logic              phase_a_next;
	logic              phase_b_next;

	assign update = step & advance;

	// counter advance and compare against the new count
	always_comb begin
		cnt_next = counter_q + CNT_W'(1);
		for (int i = 0; i < NUM_CH; i++) begin
			match[i] = (compare_q[i] == cnt_next);
		end
		pend = pending_q | match;
	end

	// lowest pending channel is served
	always_comb begin
		any  = 1'b1;
		chan = CH_SIDEREAL;
		if (pend[0]) begin
			chan = CH_SIDEREAL;
		end else if (pend[1]) begin
			chan = CH_AXIS_A;
		end else if (pend[2]) begin
			chan = CH_AXIS_B;
		end else if (pend[3]) begin
			chan = CH_CONTROL;
		end else begin
			any = 1'b0;
		end
		pend_next = pend;
		if (any) begin
			pend_next[chan] = 1'b0;
		end
	end

	// step channel decisions
	assign a_start = any && (chan == CH_AXIS_A) && cfg.a_en && !phase_a_q;
	assign b_start = any && (chan == CH_AXIS_B) && cfg.b_en && !phase_b_q;
	assign phase_a_next = (any && (chan == CH_AXIS_A)) ? a_start : phase_a_q;
	assign phase_b_next = (any && (chan == CH_AXIS_B)) ? b_start : phase_b_q;

	// compare advance of the served channel, one shared adder
	always_comb begin
		case (chan)
			CH_SIDEREAL: delta = cfg.sid_period;
			CH_AXIS_A: begin
				if (!cfg.a_en) begin
					delta = cfg.a_period;
				end else if (phase_a_q) begin
					delta = cfg.a_low_span;
				end else begin
					delta = PULSE_COUNTS;
				end
			end
			CH_AXIS_B: begin
				if (!cfg.b_en) begin
					delta = cfg.b_period;
				end else if (phase_b_q) begin
					delta = cfg.b_low_span;
				end else begin
					delta = PULSE_COUNTS;
				end
			end
			default: delta = cfg.ctl_period;
		endcase
		cmp_next = compare_q[chan] + delta;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			compare_q[0] <= CH1_RESET_COMPARE;
			for (int i = 1; i < NUM_CH; i++) begin
				compare_q[i] <= DEFAULT_PERIOD;
			end
			pending_q <= '0;
			phase_a_q <= 1'b0;
			phase_b_q <= 1'b0;
		end else if (update) begin
			counter_q <= cnt_next;
			pending_q <= pend_next;
			phase_a_q <= phase_a_next;
			phase_b_q <= phase_b_next;
			if (any) begin
				compare_q[chan] <= cmp_next;
			end
		end
	end

	// result of the current request; a held count reports levels only
	always_comb begin
		res.a_level   = update ? phase_a_next : phase_a_q;
		res.b_level   = update ? phase_b_next : phase_b_q;
		res.a_started = update & a_start;
		res.b_started = update & b_start;
		res.sid_tick  = update & any & (chan == CH_SIDEREAL) & cfg.sid_en;
		res.ctl_tick  = update & any & (chan == CH_CONTROL);
	end

endmodule

// ===== rtl/dual_axis_step_pulse_scheduler_top.sv =====
// dual_axis_step_pulse_scheduler_top: configuration registers, request input stage, compare core and result register
// depends on dasp_pkg, dasp_cfg_regs and dasp_compare_core
// a request accepted into the input request register moves on to the result register
// throughput: one request per cycle unless stalled; the compare core state update sets it
// output register stalls the input stage only when a result waits and out_ready is low
// reset: arst_n clears counter, pending flags, pin phases and valids, loads default registers
module dual_axis_step_pulse_scheduler_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [dasp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dasp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            count_advance,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            axis_a_step_level,
	output logic                            axis_b_step_level,
	output logic                            axis_a_step_started,
	output logic                            axis_b_step_started,
	output logic                            sidereal_tick,
	output logic                            control_tick
);
	import dasp_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t res_q;
	logic valid_s1;
	logic advance_s1;
	logic out_valid_q;
	logic move_s1;

	// configuration registers
	dasp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage one moves into the result register when that is free or being drained
	assign move_s1  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || move_s1;

	// input request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			advance_s1 <= count_advance;
		end
	end

	// counter and compare channels
	dasp_compare_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (move_s1),
		.advance (advance_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			res_q <= res;
		end
	end

	assign out_valid           = out_valid_q;
	assign axis_a_step_level   = res_q.a_level;
	assign axis_b_step_level   = res_q.b_level;
	assign axis_a_step_started = res_q.a_started;
	assign axis_b_step_started = res_q.b_started;
	assign sidereal_tick       = res_q.sid_tick;
	assign control_tick        = res_q.ctl_tick;

endmodule
